FILE: rtl/knn_pkg.sv
// Shared types and constants for the k-th nearest neighbor distance score unit.
// No dependencies; every other file but knn_ram imports this package.
package knn_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int MAX_DIMS     = 8;
    localparam int FEATURE_BITS = 16;
    localparam int MAX_K        = 16;

    localparam int PT_W    = $clog2(MAX_POINTS);
    localparam int DIM_W   = $clog2(MAX_DIMS);
    localparam int ADDR_W  = PT_W + DIM_W;
    localparam int PC_W    = PT_W + 1;
    localparam int FC_W    = DIM_W + 1;
    localparam int K_W     = $clog2(MAX_K);
    localparam int SQ_W    = 2 * FEATURE_BITS;
    localparam int DIST_W  = SQ_W + DIM_W;
    localparam int SQRT_W  = DIST_W + 1;
    localparam int ROOT_W  = SQRT_W / 2;
    localparam int SQRT_TOP = SQRT_W - 2;
    localparam int KTH_W   = 20;
    localparam int SCORE_W = 16;
    localparam int QUO_W   = SCORE_W + 1;
    localparam int STEP_W  = 5;

    // Set size thresholds that choose the neighbor rank.
    localparam int SMALL_SET = 50;
    localparam int MID_SET   = 200;
    localparam int K_SMALL   = 3;
    localparam int K_MID     = 5;
    localparam int K_LARGE   = 10;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FEW     = 2'd1,
        ST_MANY    = 2'd2,
        ST_UNEQUAL = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_ERR,
        S_PAIRS,
        S_DRAIN,
        S_SQRT,
        S_SCORE_RD,
        S_SCORE_CALC,
        S_DIV,
        S_EMIT
    } state_t;

    // Control word broadcast to every sorting cell.
    typedef struct packed {
        logic              ins;
        logic              clr;
        logic [DIST_W-1:0] sq_dist;
    } cell_ctl_t;

endpackage

FILE: rtl/knn_if.sv
// Handshake interfaces for the feature input channel and the score output channel.
// Depends on knn_pkg.
interface knn_in_if import knn_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic signed [FEATURE_BITS-1:0] feature_value;
    logic                           point_end;
    logic                           set_end;

    modport source (output valid, feature_value, point_end, set_end, input ready);
    modport sink (input valid, feature_value, point_end, set_end, output ready);
endinterface

interface knn_out_if import knn_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] score;
    logic [PT_W-1:0]    point_number;
    status_t            status;
    logic               last;

    modport source (output valid, score, point_number, status, last, input ready);
    modport sink (input valid, score, point_number, status, last, output ready);
endinterface

FILE: rtl/knn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module knn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/knn_cell.sv
// One cell of the sorted insertion chain that keeps the nearest squared distances.
// Depends on knn_pkg.
module knn_cell import knn_pkg::*; (
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic              head,
    input  logic [DIST_W-1:0] left_val,
    output logic [DIST_W-1:0] val
);

    logic [DIST_W-1:0] val_reg;
    logic [DIST_W-1:0] val_next;
    logic [DIST_W-1:0] own;
    logic [DIST_W-1:0] left_eff;

    // A clear makes the chain look empty: every slot holds the largest value.
    always_comb
    begin
        own      = ctl.clr ? DIST_MAX : val_reg;
        left_eff = head ? '0 : (ctl.clr ? DIST_MAX : left_val);
        val_next = val_reg;
        if (ctl.ins)
        begin
            val_next = own;
            if (ctl.sq_dist < own)
            begin
                val_next = (ctl.sq_dist >= left_eff) ? ctl.sq_dist : left_eff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

FILE: rtl/knn_sqrt.sv
// Iterative integer square root, one result bit per step from two radicand bits, one step a cycle.
// Depends on knn_pkg.
module knn_sqrt import knn_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIST_W-1:0] value,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [SQRT_W-1:0] v_reg, v_next;
    logic [SQRT_W-1:0] res_reg, res_next;
    logic [SQRT_W-1:0] bit_reg, bit_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [SQRT_W-1:0] sum;

    // One digit of the root per cycle.
    always_comb
    begin
        sum       = res_reg + bit_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next   = SQRT_W'(value);
            res_next = '0;
            bit_next = SQRT_W'(1) << SQRT_TOP;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (v_reg >= sum)
            begin
                v_next   = v_reg - sum;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(ROOT_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

FILE: rtl/knn_div.sv
// Restoring divider for the score: (num * 2^16) / den, one quotient bit a cycle.
// Depends on knn_pkg.
module knn_div import knn_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KTH_W-1:0] num,
    input  logic [KTH_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    logic [KTH_W:0]    rem_reg, rem_next;
    logic [KTH_W-1:0]  den_reg, den_next;
    logic [QUO_W-1:0]  q_reg, q_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [KTH_W:0]    trial;
    logic              ge;

    // The first step compares without a shift; the remaining ones shift in a zero.
    always_comb
    begin
        trial     = (cnt_reg == '0) ? rem_reg : {rem_reg[KTH_W-1:0], 1'b0};
        ge        = trial >= {1'b0, den_reg};
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = {1'b0, num};
            den_next = den;
            q_next   = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? (trial - {1'b0, den_reg}) : trial;
            q_next   = {q_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(QUO_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

FILE: rtl/knn_distance_score_unit.sv
// Top level of the k-th nearest neighbor distance score unit.
// Depends on knn_pkg, knn_if, knn_ram, knn_cell, knn_sqrt and knn_div.
//
//  Channel  Dir  Word                                          Accepted when
//  feed     in   feature_value, point_end, set_end             valid && ready
//  result   out  score, point_number, status, last             valid && ready
//
// Loading takes one word per cycle. After set end the feed is held off through a
// check state. Each point then runs its pair work and draining through the sorting
// chain, then a square root of its k-th distance. Each score then takes a read and
// a division (no division when the largest distance is zero) before it is offered.
// An error set answers with one word after the check state. Reset clears all control
// state; the feature store needs none. A stalled result simply holds the unit until
// the word is taken.
module knn_distance_score_unit import knn_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    knn_in_if.sink    feed,
    knn_out_if.source result
);

    state_t state_reg, state_next;

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [FC_W-1:0]   fc_reg, fc_next;
    logic [FC_W-1:0]   dims_reg, dims_next;
    logic              unequal_reg, unequal_next;
    logic              many_reg, many_next;
    logic [KTH_W-1:0]  largest_reg, largest_next;
    logic [K_W-1:0]    k_reg, k_next;

    logic [PT_W-1:0]   i_reg, i_next;
    logic [PT_W-1:0]   j_reg, j_next;
    logic [DIM_W-1:0]  f_reg, f_next;
    logic              first_pend_reg, first_pend_next;

    logic [SCORE_W-1:0] score_reg, score_next;
    logic [PT_W-1:0]    pn_reg, pn_next;
    status_t            status_reg, status_next;
    logic               last_reg, last_next;

    logic              accept;
    logic [FC_W-1:0]   fc_inc;
    logic [PC_W-1:0]   pc_inc;
    logic              store_we;
    logic [ADDR_W-1:0] store_waddr;
    logic [K_W:0]      k_pick;

    logic              issue;
    logic              last_f;
    logic              last_j;
    logic              i_last;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [FEATURE_BITS-1:0] rd_a;
    logic [FEATURE_BITS-1:0] rd_b;

    // Pair pipeline: read, absolute difference, square, accumulate.
    logic v1_reg, ff1_reg, lf1_reg, fj1_reg;
    logic v2_reg, ff2_reg, lf2_reg, fj2_reg;
    logic v3_reg, ff3_reg, lf3_reg, fj3_reg;
    logic [FEATURE_BITS-1:0] diff_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [DIST_W-1:0]       acc_reg;
    logic                    ins_reg;
    logic                    clr_reg;
    logic signed [FEATURE_BITS:0] diff_s;
    logic [FEATURE_BITS-1:0]      diff_abs;

    cell_ctl_t         ctl;
    logic [DIST_W-1:0] cell_val [MAX_K];
    logic [DIST_W-1:0] kth_sq;

    logic              sqrt_start;
    logic              sqrt_done;
    logic [ROOT_W-1:0] root;
    logic              kth_we;
    logic [KTH_W-1:0]  kth_rd;
    logic              div_start;
    logic              div_done;
    logic [QUO_W-1:0]  quo;

    assign accept = feed.valid && feed.ready;
    assign feed.ready = (state_reg == S_LOAD);

    // Feature store: two copies so both points of a pair are read in the same cycle.
    assign store_we    = accept && (pc_reg < PC_W'(MAX_POINTS)) && (fc_reg < FC_W'(MAX_DIMS));
    assign store_waddr = {pc_reg[PT_W-1:0], fc_reg[DIM_W-1:0]};
    assign addr_a      = {i_reg, f_reg};
    assign addr_b      = {j_reg, f_reg};

    knn_ram #(.WIDTH(FEATURE_BITS), .DEPTH(MAX_POINTS * MAX_DIMS)) u_store_a (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (feed.feature_value),
        .raddr (addr_a),
        .rdata (rd_a)
    );

    knn_ram #(.WIDTH(FEATURE_BITS), .DEPTH(MAX_POINTS * MAX_DIMS)) u_store_b (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (feed.feature_value),
        .raddr (addr_b),
        .rdata (rd_b)
    );

    // Issue control for the pair sweep.
    assign issue  = (state_reg == S_PAIRS) && (j_reg != i_reg);
    assign last_f = ({1'b0, f_reg} == dims_reg - FC_W'(1));
    assign i_last = ({1'b0, i_reg} == pc_reg - PC_W'(1));
    assign last_j = ({1'b0, j_reg} == pc_reg - PC_W'(1))
                    || (({1'b0, j_reg} == pc_reg - PC_W'(2)) && i_last);

    // Difference of the two features, made unsigned.
    always_comb
    begin
        diff_s   = $signed({rd_a[FEATURE_BITS-1], rd_a}) - $signed({rd_b[FEATURE_BITS-1], rd_b});
        diff_abs = diff_s[FEATURE_BITS] ? FEATURE_BITS'(-diff_s) : diff_s[FEATURE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            ins_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= issue;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            ins_reg <= v3_reg && lf3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ff1_reg  <= (f_reg == '0);
        lf1_reg  <= last_f;
        fj1_reg  <= first_pend_reg;
        ff2_reg  <= ff1_reg;
        lf2_reg  <= lf1_reg;
        fj2_reg  <= fj1_reg;
        diff_reg <= diff_abs;
        ff3_reg  <= ff2_reg;
        lf3_reg  <= lf2_reg;
        fj3_reg  <= fj2_reg;
        sq_reg   <= diff_reg * diff_reg;
        clr_reg  <= fj3_reg;
        if (v3_reg)
        begin
            acc_reg <= (ff3_reg ? '0 : acc_reg) + DIST_W'(sq_reg);
        end
    end

    // Sorting chain of the nearest squared distances.
    assign ctl.ins     = ins_reg;
    assign ctl.clr     = clr_reg;
    assign ctl.sq_dist = acc_reg;

    for (genvar c = 0; c < MAX_K; c++)
    begin : g_cell
        knn_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .head     (c == 0),
            .left_val (cell_val[(c == 0) ? 0 : c - 1]),
            .val      (cell_val[c])
        );
    end

    assign kth_sq = cell_val[k_reg - K_W'(1)];

    knn_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (kth_sq),
        .done  (sqrt_done),
        .root  (root)
    );

    // Per-point k-th distance store.
    assign kth_we = (state_reg == S_SQRT) && sqrt_done;

    knn_ram #(.WIDTH(KTH_W), .DEPTH(MAX_POINTS)) u_kth (
        .clk   (clk),
        .we    (kth_we),
        .waddr (i_reg),
        .wdata (KTH_W'(root)),
        .raddr (i_reg),
        .rdata (kth_rd)
    );

    knn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (kth_rd),
        .den   (largest_reg),
        .done  (div_done),
        .quo   (quo)
    );

    // Neighbor rank for the set size, limited to N-1.
    always_comb
    begin
        if (pc_reg <= PC_W'(SMALL_SET))
        begin
            k_pick = (K_W + 1)'(K_SMALL);
        end
        else if ({1'b0, pc_reg} <= 8'(MID_SET))
        begin
            k_pick = (K_W + 1)'(K_MID);
        end
        else
        begin
            k_pick = (K_W + 1)'(K_LARGE);
        end
        if (PC_W'(k_pick) > pc_reg - PC_W'(1))
        begin
            k_pick = (K_W + 1)'(pc_reg - PC_W'(1));
        end
    end

    assign fc_inc = (fc_reg <= FC_W'(MAX_DIMS)) ? fc_reg + FC_W'(1) : fc_reg;
    assign pc_inc = (pc_reg <= PC_W'(MAX_POINTS)) ? pc_reg + PC_W'(1) : pc_reg;

    // Sequencer: load, check, error reply, pair sweep, root, scoring and output.
    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        fc_next         = fc_reg;
        dims_next       = dims_reg;
        unequal_next    = unequal_reg;
        many_next       = many_reg;
        largest_next    = largest_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        f_next          = f_reg;
        first_pend_next = first_pend_reg;
        score_next      = score_reg;
        pn_next         = pn_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        sqrt_start      = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    fc_next = fc_inc;
                    if (feed.point_end || feed.set_end)
                    begin
                        if (fc_inc > FC_W'(MAX_DIMS))
                        begin
                            unequal_next = 1'b1;
                        end
                        if (pc_reg == '0)
                        begin
                            dims_next = fc_inc;
                        end
                        else if (fc_inc != dims_reg)
                        begin
                            unequal_next = 1'b1;
                        end
                        pc_next = pc_inc;
                        if (pc_inc > PC_W'(MAX_POINTS))
                        begin
                            many_next = 1'b1;
                        end
                        fc_next = '0;
                    end
                    if (feed.set_end)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                score_next      = '0;
                pn_next         = '0;
                last_next       = 1'b1;
                k_next          = k_pick[K_W-1:0];
                i_next          = '0;
                j_next          = '0;
                f_next          = '0;
                first_pend_next = 1'b1;
                largest_next    = '0;
                if (pc_reg < PC_W'(2))
                begin
                    status_next = ST_FEW;
                    state_next  = S_ERR;
                end
                else if (many_reg)
                begin
                    status_next = ST_MANY;
                    state_next  = S_ERR;
                end
                else if (unequal_reg)
                begin
                    status_next = ST_UNEQUAL;
                    state_next  = S_ERR;
                end
                else
                begin
                    status_next = ST_OK;
                    state_next  = S_PAIRS;
                end
            end
            S_ERR:
            begin
                if (result.ready)
                begin
                    pc_next      = '0;
                    fc_next      = '0;
                    dims_next    = '0;
                    unequal_next = 1'b0;
                    many_next    = 1'b0;
                    largest_next = '0;
                    state_next   = S_LOAD;
                end
            end
            S_PAIRS:
            begin
                if (!issue)
                begin
                    j_next = j_reg + PT_W'(1);
                end
                else if (last_f)
                begin
                    f_next          = '0;
                    first_pend_next = 1'b0;
                    if (last_j)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + PT_W'(1);
                    end
                end
                else
                begin
                    f_next = f_reg + DIM_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!(v1_reg || v2_reg || v3_reg || ins_reg))
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    if (KTH_W'(root) > largest_reg)
                    begin
                        largest_next = KTH_W'(root);
                    end
                    j_next          = '0;
                    f_next          = '0;
                    first_pend_next = 1'b1;
                    if (i_last)
                    begin
                        i_next     = '0;
                        state_next = S_SCORE_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + PT_W'(1);
                        state_next = S_PAIRS;
                    end
                end
            end
            S_SCORE_RD:
            begin
                state_next = S_SCORE_CALC;
            end
            S_SCORE_CALC:
            begin
                pn_next     = i_reg;
                status_next = ST_OK;
                last_next   = i_last;
                if (largest_reg == '0)
                begin
                    score_next = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    score_next = quo[QUO_W-1] ? '1 : quo[SCORE_W-1:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (result.ready)
                begin
                    if (i_last)
                    begin
                        pc_next      = '0;
                        fc_next      = '0;
                        dims_next    = '0;
                        unequal_next = 1'b0;
                        many_next    = 1'b0;
                        largest_next = '0;
                        i_next       = '0;
                        state_next   = S_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + PT_W'(1);
                        state_next = S_SCORE_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            pc_reg         <= '0;
            fc_reg         <= '0;
            dims_reg       <= '0;
            unequal_reg    <= 1'b0;
            many_reg       <= 1'b0;
            largest_reg    <= '0;
            k_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            f_reg          <= '0;
            first_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            fc_reg         <= fc_next;
            dims_reg       <= dims_next;
            unequal_reg    <= unequal_next;
            many_reg       <= many_next;
            largest_reg    <= largest_next;
            k_reg          <= k_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            f_reg          <= f_next;
            first_pend_reg <= first_pend_next;
        end
    end

    // Output word registers.
    always_ff @(posedge clk)
    begin
        score_reg  <= score_next;
        pn_reg     <= pn_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign result.valid        = (state_reg == S_EMIT) || (state_reg == S_ERR);
    assign result.score        = score_reg;
    assign result.point_number = pn_reg;
    assign result.status       = status_reg;
    assign result.last         = last_reg;

    // Loading and delivering never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(feed.ready && result.valid))
        else $error("feed open while a result word is offered");

    // The final word of a set hands the unit back to loading.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last) |=> feed.ready)
        else $error("unit did not return to loading after the last word");

    // Good scores only name points that exist in the set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_OK) |-> ({1'b0, result.point_number} < pc_reg))
        else $error("score for a point outside the set");

    // The sorting chain only moves during the pair sweep and its drain.
    assert property (@(posedge clk) disable iff (!rst_n)
        ins_reg |-> (state_reg == S_PAIRS || state_reg == S_DRAIN))
        else $error("chain insert outside the pair sweep");

    // A root is started only once the pair pipeline is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !(v1_reg || v2_reg || v3_reg || ins_reg))
        else $error("square root started with pairs in flight");

endmodule
